@@ design/lbs_pkg.sv @@
// shared types, constants and register codes of the letterbox bilinear scaler
// no dependencies; every other design file imports this package
package lbs_pkg;

  // frame store and destination limits
  localparam int unsigned SRC_MAX_SIDE = 256;
  localparam int unsigned DST_MAX_SIDE = 4096;
  localparam int unsigned SRC_RESET    = 256;
  localparam int unsigned DST_RESET    = 256;

  // field widths
  localparam int unsigned SRC_CW = 8;   // source column / row
  localparam int unsigned SRC_SW = 9;   // source size register
  localparam int unsigned DST_CW = 12;  // destination column / row
  localparam int unsigned DST_SW = 13;  // destination size register
  localparam int unsigned PIX_W  = 24;  // stored pixel
  localparam int unsigned ADDR_W = 5;   // config byte address

  // fit divider: product of a destination size and a source size
  localparam int unsigned PROD_W = DST_SW + SRC_SW;
  localparam int unsigned PCNT_W = $clog2(PROD_W);

  // per-item coordinate divider, 16.16 positions below 2^24
  localparam int unsigned N_W        = DST_CW + 1 + SRC_SW;
  localparam int unsigned DIV_STEPS  = 24;
  localparam int unsigned HALF_SHIFT = 15;
  localparam int unsigned R_W        = N_W + HALF_SHIFT - DIV_STEPS;
  localparam logic [DIV_STEPS-1:0] HALF_PIX = DIV_STEPS'(32768);

  // frame store banks, split by column and row parity
  localparam int unsigned BANK_AW = 2 * (SRC_CW - 1);
  localparam int unsigned BANKS   = 4;

  // queues
  localparam int unsigned MQ_DEPTH = 4;
  localparam int unsigned OQ_DEPTH = 32;

  // pixel constants
  localparam logic [31:0] BG_PIXEL = 32'hff111111;
  localparam logic [7:0]  ALPHA    = 8'hff;

  // operation codes
  localparam logic FUNC_LOAD = 1'b0;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SWAP_RB    = 3'd4,
    REG_FLIP_ROWS  = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    FIT_IDLE,
    FIT_START,
    FIT_DIV_H,
    FIT_CHECK,
    FIT_DIV_W,
    FIT_TAKE_W,
    FIT_OFFSET
  } fit_state_e;

  // configuration and fitted rectangle
  typedef struct packed {
    logic [SRC_SW-1:0] src_width;
    logic [SRC_SW-1:0] src_height;
    logic [DST_SW-1:0] dst_width;
    logic [DST_SW-1:0] dst_height;
    logic [DST_SW-1:0] fit_w;
    logic [DST_SW-1:0] fit_h;
    logic [DST_CW-1:0] off_x;
    logic [DST_CW-1:0] off_y;
    logic              swap;
    logic              flip;
    logic              busy;
  } cfg_t;

  // classified item between front and back
  typedef struct packed {
    logic              load;
    logic              border;
    logic [DST_CW-1:0] pos_x;
    logic [DST_CW-1:0] pos_y;
    logic [PIX_W-1:0]  pixel;
  } item_t;

  // side band carried along the back pipeline
  typedef struct packed {
    logic              load;
    logic              border;
    logic [SRC_CW-1:0] col;
    logic [SRC_CW-1:0] row;
    logic [PIX_W-1:0]  pixel;
  } tag_t;

  // one step of the restoring divider
  typedef struct packed {
    logic [R_W-1:0]       r;
    logic [DIV_STEPS-1:0] l;
  } dstep_t;

  // result entry
  typedef struct packed {
    logic [31:0] pixel;
    logic        border;
  } res_t;

endpackage

@@ design/lbs_fit.sv @@
// configuration registers and fitted-rectangle computation
// depends on lbs_pkg; a bit-serial divider recomputes the fit after each write
module lbs_fit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output lbs_pkg::cfg_t              cfg_o
);
  import lbs_pkg::*;

  function automatic logic [SRC_SW-1:0] clamp_src(input logic [SRC_SW-1:0] v);
    logic [SRC_SW-1:0] r;
    if (v == '0) r = SRC_SW'(1);
    else if (v > SRC_SW'(SRC_MAX_SIDE)) r = SRC_SW'(SRC_MAX_SIDE);
    else r = v;
    return r;
  endfunction

  function automatic logic [DST_SW-1:0] clamp_dst(input logic [DST_SW-1:0] v);
    logic [DST_SW-1:0] r;
    if (v == '0) r = DST_SW'(1);
    else if (v > DST_SW'(DST_MAX_SIDE)) r = DST_SW'(DST_MAX_SIDE);
    else r = v;
    return r;
  endfunction

  logic [SRC_SW-1:0] src_w_q, src_h_q;
  logic [DST_SW-1:0] dst_w_q, dst_h_q;
  logic              swap_q, flip_q;
  logic [DST_SW-1:0] fit_w_q, fit_h_q;
  logic [DST_CW-1:0] off_x_q, off_y_q;
  fit_state_e        state_q, state_d;
  logic [PROD_W-1:0] quo_q;
  logic [SRC_SW-1:0] rem_q, dvs_q;
  logic [PCNT_W-1:0] cnt_q;
  logic              wr_en;
  reg_idx_e          idx;
  logic              last_step, too_tall;
  logic              ld_h, ld_w, step, take_h, take_w, set_off;
  logic [SRC_SW:0]   rr, rs;
  logic              ge;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  // register writes with size clamping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_SW'(SRC_RESET);
      src_h_q <= SRC_SW'(SRC_RESET);
      dst_w_q <= DST_SW'(DST_RESET);
      dst_h_q <= DST_SW'(DST_RESET);
      swap_q  <= 1'b0;
      flip_q  <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SRC_WIDTH:  src_w_q <= clamp_src(pwdata[SRC_SW-1:0]);
        REG_SRC_HEIGHT: src_h_q <= clamp_src(pwdata[SRC_SW-1:0]);
        REG_DST_WIDTH:  dst_w_q <= clamp_dst(pwdata[DST_SW-1:0]);
        REG_DST_HEIGHT: dst_h_q <= clamp_dst(pwdata[DST_SW-1:0]);
        REG_SWAP_RB:    swap_q  <= pwdata[0];
        REG_FLIP_ROWS:  flip_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (idx)
      REG_SRC_WIDTH:  prdata = 32'(src_w_q);
      REG_SRC_HEIGHT: prdata = 32'(src_h_q);
      REG_DST_WIDTH:  prdata = 32'(dst_w_q);
      REG_DST_HEIGHT: prdata = 32'(dst_h_q);
      REG_SWAP_RB:    prdata = 32'(swap_q);
      REG_FLIP_ROWS:  prdata = 32'(flip_q);
      default:        prdata = '0;
    endcase
  end

  assign last_step = (cnt_q == PCNT_W'(PROD_W - 1));
  assign too_tall  = (quo_q > PROD_W'(dst_h_q));

  // fit sequencer next state; any write restarts it
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FIT_IDLE:   state_d = FIT_IDLE;
      FIT_START:  state_d = FIT_DIV_H;
      FIT_DIV_H:  if (last_step) state_d = FIT_CHECK;
      FIT_CHECK:  state_d = too_tall ? FIT_DIV_W : FIT_OFFSET;
      FIT_DIV_W:  if (last_step) state_d = FIT_TAKE_W;
      FIT_TAKE_W: state_d = FIT_OFFSET;
      FIT_OFFSET: state_d = FIT_IDLE;
      default:    state_d = FIT_IDLE;
    endcase
    if (wr_en) state_d = FIT_START;
  end

  // fit sequencer outputs
  always_comb begin
    ld_h    = (state_q == FIT_START);
    step    = (state_q == FIT_DIV_H) | (state_q == FIT_DIV_W);
    ld_w    = (state_q == FIT_CHECK) & too_tall;
    take_h  = (state_q == FIT_CHECK) & ~too_tall;
    take_w  = (state_q == FIT_TAKE_W);
    set_off = (state_q == FIT_OFFSET);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= FIT_IDLE;
    else         state_q <= state_d;
  end

  // one quotient bit per cycle
  assign rr = {rem_q, quo_q[PROD_W-1]};
  assign ge = (rr >= {1'b0, dvs_q});
  assign rs = ge ? rr - {1'b0, dvs_q} : rr;

  always_ff @(posedge clk_i) begin
    if (ld_h) begin
      quo_q <= PROD_W'(dst_w_q) * PROD_W'(src_h_q);
      dvs_q <= src_w_q;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (ld_w) begin
      quo_q <= PROD_W'(dst_h_q) * PROD_W'(src_w_q);
      dvs_q <= src_h_q;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (step) begin
      quo_q <= {quo_q[PROD_W-2:0], ge};
      rem_q <= rs[SRC_SW-1:0];
      cnt_q <= cnt_q + PCNT_W'(1);
    end
  end

  // fitted size and centring offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_w_q <= DST_SW'(DST_RESET);
      fit_h_q <= DST_SW'(DST_RESET);
      off_x_q <= '0;
      off_y_q <= '0;
    end else begin
      if (ld_w) fit_h_q <= dst_h_q;
      if (take_h) begin
        fit_w_q <= dst_w_q;
        fit_h_q <= quo_q[DST_SW-1:0];
      end
      if (take_w) fit_w_q <= quo_q[DST_SW-1:0];
      if (set_off) begin
        off_x_q <= DST_CW'((dst_w_q - fit_w_q) >> 1);
        off_y_q <= DST_CW'((dst_h_q - fit_h_q) >> 1);
      end
    end
  end

  always_comb begin
    cfg_o.src_width  = src_w_q;
    cfg_o.src_height = src_h_q;
    cfg_o.dst_width  = dst_w_q;
    cfg_o.dst_height = dst_h_q;
    cfg_o.fit_w      = fit_w_q;
    cfg_o.fit_h      = fit_h_q;
    cfg_o.off_x      = off_x_q;
    cfg_o.off_y      = off_y_q;
    cfg_o.swap       = swap_q;
    cfg_o.flip       = flip_q;
    cfg_o.busy       = (state_q != FIT_IDLE);
  end

endmodule

@@ design/lbs_front.sv @@
// front end: takes items, classifies loads, samples and background points
// depends on lbs_pkg and the fitted rectangle from lbs_fit
module lbs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lbs_pkg::cfg_t              cfg_i,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic                       func_i,
  input  logic [lbs_pkg::SRC_CW-1:0] src_col_i,
  input  logic [lbs_pkg::SRC_CW-1:0] src_row_i,
  input  logic [31:0]                src_pixel_i,
  input  logic [lbs_pkg::DST_CW-1:0] dst_col_i,
  input  logic [lbs_pkg::DST_CW-1:0] dst_row_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output lbs_pkg::item_t             q_item_o
);
  import lbs_pkg::*;

  logic              vld_q;
  item_t             item_q, item_d;
  logic              accept, move;
  logic [DST_SW-1:0] xo, yo;
  logic              in_x, in_y;

  assign move     = vld_q & ~q_full_i;
  assign full_o   = cfg_i.busy | (vld_q & q_full_i);
  assign accept   = push_i & ~full_o;
  assign q_push_o = move;
  assign q_item_o = item_q;

  // offset into the fitted rectangle and inside test
  assign xo = {1'b0, dst_col_i} - {1'b0, cfg_i.off_x};
  assign yo = {1'b0, dst_row_i} - {1'b0, cfg_i.off_y};
  assign in_x = ({1'b0, dst_col_i} < cfg_i.dst_width) & (dst_col_i >= cfg_i.off_x)
              & (xo < cfg_i.fit_w);
  assign in_y = ({1'b0, dst_row_i} < cfg_i.dst_height) & (dst_row_i >= cfg_i.off_y)
              & (yo < cfg_i.fit_h);

  always_comb begin
    item_d.load   = (func_i == FUNC_LOAD);
    item_d.border = ~(in_x & in_y);
    item_d.pos_x  = item_d.load ? DST_CW'(src_col_i) : xo[DST_CW-1:0];
    item_d.pos_y  = item_d.load ? DST_CW'(src_row_i) : yo[DST_CW-1:0];
    item_d.pixel  = src_pixel_i[PIX_W-1:0];
  end

  // holding stage in front of the item queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (accept) vld_q <= 1'b1;
    else if (move) vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_d;
  end

endmodule

@@ design/lbs_fifo.sv @@
// short item queue between front and back
// depends on lbs_pkg for the item type
module lbs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lbs_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output lbs_pkg::item_t item_o,
  output logic           empty_o
);
  import lbs_pkg::*;

  localparam int unsigned PTR_W = $clog2(MQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(MQ_DEPTH + 1);

  item_t             mem_q [MQ_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(MQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PTR_W'(MQ_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      if (do_pop)  rd_q <= (rd_q == PTR_W'(MQ_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

@@ design/lbs_back.sv @@
// back end: coordinate mapping, banked frame store, bilinear blend, result queue
// depends on lbs_pkg and the configuration from lbs_fit
module lbs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lbs_pkg::cfg_t  cfg_i,
  input  logic           q_empty_i,
  input  lbs_pkg::item_t q_item_i,
  output logic           q_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [31:0]    out_pixel_o,
  output logic           in_border_o
);
  import lbs_pkg::*;

  localparam int unsigned CR_W   = $clog2(OQ_DEPTH + 1);
  localparam int unsigned OPTR_W = $clog2(OQ_DEPTH);

  function automatic dstep_t div_step(input dstep_t s, input logic [DST_SW-1:0] d);
    dstep_t         o;
    logic [R_W:0]   rr;
    logic           ge;
    rr  = {s.r, s.l[DIV_STEPS-1]};
    ge  = (rr >= (R_W+1)'(d));
    rr  = ge ? rr - (R_W+1)'(d) : rr;
    o.r = rr[R_W-1:0];
    o.l = {s.l[DIV_STEPS-2:0], ge};
    return o;
  endfunction

  function automatic logic [7:0] blend(input logic [7:0] p, input logic [7:0] q,
                                       input logic [7:0] w);
    logic [16:0] s;
    s = 17'(p) * (17'(256) - 17'(w)) + 17'(q) * 17'(w);
    return s[15:8];
  endfunction

  // issue and result credits
  logic            issue;
  logic [CR_W-1:0] credit_q;
  logic            out_pop;

  assign issue   = ~q_empty_i & (q_item_i.load | (credit_q < CR_W'(OQ_DEPTH)));
  assign q_pop_o = issue;
  assign out_pop = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) credit_q <= '0;
    else credit_q <= credit_q + CR_W'(issue & ~q_item_i.load) - CR_W'(out_pop);
  end

  // stage 1: numerators (2p+1) * source size
  logic           v1_q;
  tag_t           t1_q;
  logic [N_W-1:0] nx_q, ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= issue;
  end

  always_ff @(posedge clk_i) begin
    t1_q.load   <= q_item_i.load;
    t1_q.border <= q_item_i.border;
    t1_q.col    <= q_item_i.pos_x[SRC_CW-1:0];
    t1_q.row    <= q_item_i.pos_y[SRC_CW-1:0];
    t1_q.pixel  <= q_item_i.pixel;
    nx_q <= N_W'({q_item_i.pos_x, 1'b1}) * N_W'(cfg_i.src_width);
    ny_q <= N_W'({q_item_i.pos_y, 1'b1}) * N_W'(cfg_i.src_height);
  end

  // divider pipeline: one quotient bit per stage for each axis
  logic [DIV_STEPS-1:0] dv_q;
  tag_t   dt_q [DIV_STEPS];
  dstep_t dx_q [DIV_STEPS];
  dstep_t dy_q [DIV_STEPS];
  dstep_t dx_in [DIV_STEPS];
  dstep_t dy_in [DIV_STEPS];

  always_comb begin
    dx_in[0].r = nx_q[N_W-1 -: R_W];
    dx_in[0].l = {nx_q[N_W-R_W-1:0], {HALF_SHIFT{1'b0}}};
    dy_in[0].r = ny_q[N_W-1 -: R_W];
    dy_in[0].l = {ny_q[N_W-R_W-1:0], {HALF_SHIFT{1'b0}}};
    for (int k = 1; k < DIV_STEPS; k++) begin
      dx_in[k] = dx_q[k-1];
      dy_in[k] = dy_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= '0;
    else dv_q <= {dv_q[DIV_STEPS-2:0], v1_q};
  end

  always_ff @(posedge clk_i) begin
    dt_q[0] <= t1_q;
    for (int k = 1; k < DIV_STEPS; k++) dt_q[k] <= dt_q[k-1];
    for (int k = 0; k < DIV_STEPS; k++) begin
      dx_q[k] <= div_step(dx_in[k], cfg_i.fit_w);
      dy_q[k] <= div_step(dy_in[k], cfg_i.fit_h);
    end
  end

  // stage c: pixel-centre shift, neighbours, weights, row flip
  logic [DIV_STEPS-1:0] qx, qy, fx, fy;
  logic [SRC_CW-1:0]    x0, y0, x1, y1, y0f, y1f;
  logic [SRC_SW-1:0]    x0p, y0p, y0n, y1n;

  assign qx  = dx_q[DIV_STEPS-1].l;
  assign qy  = dy_q[DIV_STEPS-1].l;
  assign fx  = (qx >= HALF_PIX) ? qx - HALF_PIX : '0;
  assign fy  = (qy >= HALF_PIX) ? qy - HALF_PIX : '0;
  assign x0  = fx[DIV_STEPS-1 -: SRC_CW];
  assign y0  = fy[DIV_STEPS-1 -: SRC_CW];
  assign x0p = {1'b0, x0} + SRC_SW'(1);
  assign y0p = {1'b0, y0} + SRC_SW'(1);
  assign x1  = (x0p < cfg_i.src_width) ? x0p[SRC_CW-1:0] : x0;
  assign y1  = (y0p < cfg_i.src_height) ? y0p[SRC_CW-1:0] : y0;
  assign y0n = cfg_i.src_height - SRC_SW'(1) - {1'b0, y0};
  assign y1n = cfg_i.src_height - SRC_SW'(1) - {1'b0, y1};
  assign y0f = cfg_i.flip ? y0n[SRC_CW-1:0] : y0;
  assign y1f = cfg_i.flip ? y1n[SRC_CW-1:0] : y1;

  logic              vc_q;
  tag_t              tc_q;
  logic [SRC_CW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [7:0]        wxc_q, wyc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else vc_q <= dv_q[DIV_STEPS-1];
  end

  always_ff @(posedge clk_i) begin
    tc_q  <= dt_q[DIV_STEPS-1];
    x0_q  <= x0;
    x1_q  <= x1;
    y0_q  <= y0f;
    y1_q  <= y1f;
    wxc_q <= fx[15:8];
    wyc_q <= fy[15:8];
  end

  // frame store: four banks by column and row parity, one read each per cycle
  logic [PIX_W-1:0] rd_q [BANKS];

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [PIX_W-1:0]   mem [2**BANK_AW];
    logic               we;
    logic [BANK_AW-1:0] wa, ra;
    logic [SRC_CW-1:0]  rc, rw;

    assign we = vc_q & tc_q.load & (tc_q.col[0] == b[0]) & (tc_q.row[0] == b[1]);
    assign wa = {tc_q.row[SRC_CW-1:1], tc_q.col[SRC_CW-1:1]};
    assign rc = (x0_q[0] == b[0]) ? x0_q : x1_q;
    assign rw = (y0_q[0] == b[1]) ? y0_q : y1_q;
    assign ra = {rw[SRC_CW-1:1], rc[SRC_CW-1:1]};

    always_ff @(posedge clk_i) begin
      if (we) mem[wa] <= tc_q.pixel;
      rd_q[b] <= mem[ra];
    end
  end

  // stage d: selects and weights alongside the store read
  logic       vd_q, bd_q;
  logic       sx0_q, sx1_q, sy0_q, sy1_q;
  logic [7:0] wxd_q, wyd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else vd_q <= vc_q & ~tc_q.load;
  end

  always_ff @(posedge clk_i) begin
    bd_q  <= tc_q.border;
    sx0_q <= x0_q[0];
    sx1_q <= x1_q[0];
    sy0_q <= y0_q[0];
    sy1_q <= y1_q[0];
    wxd_q <= wxc_q;
    wyd_q <= wyc_q;
  end

  // stage e: horizontal blend per channel
  logic [PIX_W-1:0] pa, pb, pc, pd;
  assign pa = rd_q[{sy0_q, sx0_q}];
  assign pb = rd_q[{sy0_q, sx1_q}];
  assign pc = rd_q[{sy1_q, sx0_q}];
  assign pd = rd_q[{sy1_q, sx1_q}];

  logic       ve_q, be_q;
  logic [7:0] top_q [3];
  logic [7:0] bot_q [3];
  logic [7:0] wye_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else ve_q <= vd_q;
  end

  always_ff @(posedge clk_i) begin
    be_q  <= bd_q;
    wye_q <= wyd_q;
    for (int c = 0; c < 3; c++) begin
      top_q[c] <= blend(pa[8*c +: 8], pb[8*c +: 8], wxd_q);
      bot_q[c] <= blend(pc[8*c +: 8], pd[8*c +: 8], wxd_q);
    end
  end

  // vertical blend, channel order and background into the result queue
  logic [7:0] vch [3];
  res_t       res;

  always_comb begin
    for (int c = 0; c < 3; c++) vch[c] = blend(top_q[c], bot_q[c], wye_q);
    if (be_q) begin
      res.pixel  = BG_PIXEL;
      res.border = 1'b1;
    end else begin
      res.pixel  = cfg_i.swap ? {ALPHA, vch[0], vch[1], vch[2]}
                              : {ALPHA, vch[2], vch[1], vch[0]};
      res.border = 1'b0;
    end
  end

  // result queue, sized by the issue credits
  res_t              oq_q [OQ_DEPTH];
  logic [OPTR_W-1:0] owr_q, ord_q;
  logic [CR_W-1:0]   ofill_q;

  assign empty_o     = (ofill_q == '0);
  assign out_pixel_o = oq_q[ord_q].pixel;
  assign in_border_o = oq_q[ord_q].border;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q   <= '0;
      ord_q   <= '0;
      ofill_q <= '0;
    end else begin
      if (ve_q) owr_q <= (owr_q == OPTR_W'(OQ_DEPTH - 1)) ? '0 : owr_q + OPTR_W'(1);
      if (out_pop) ord_q <= (ord_q == OPTR_W'(OQ_DEPTH - 1)) ? '0 : ord_q + OPTR_W'(1);
      ofill_q <= ofill_q + CR_W'(ve_q) - CR_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ve_q) oq_q[owr_q] <= res;
  end

endmodule

@@ design/letterbox_bilinear_scaler.sv @@
// top level of the letterbox bilinear scaler
// depends on lbs_pkg, lbs_fit, lbs_front, lbs_fifo and lbs_back
//
// Usage. Items enter through a queue-style port: an item is taken at a clock
// edge with push high and full low. func 0 loads src_pixel into the frame
// store at (src_col, src_row) and gives no result; func 1 samples the
// destination point (dst_col, dst_row) and gives exactly one result. Results
// leave through a queue-style port: while empty is low the oldest result is
// on out_pixel_o / in_border_o and is taken at an edge with pop high.
// Throughput is one item per clock while full stays low. A sample's result
// reaches the result ports through the front holding stage, an item queue
// slot, a numerator stage, a 24-stage coordinate divider, a mapping stage,
// the banked store read, a blend stage and the result queue write. The store
// is split into four banks by column and row parity so the four neighbours
// are read in the same cycle. When pop stays low, up to 32 results are held
// and then the back end stops issuing samples; the item queue and front
// stage fill and full rises. Configuration goes through the APB port; after
// each write the fitted rectangle is recomputed by a bit-serial divider,
// during which full is high. Reset sets 256x256 source and window, no swap,
// no flip; the frame store is not cleared.
module letterbox_bilinear_scaler (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       push,
  output logic                       full,
  input  logic                       func_i,
  input  logic [lbs_pkg::SRC_CW-1:0] src_col_i,
  input  logic [lbs_pkg::SRC_CW-1:0] src_row_i,
  input  logic [31:0]                src_pixel_i,
  input  logic [lbs_pkg::DST_CW-1:0] dst_col_i,
  input  logic [lbs_pkg::DST_CW-1:0] dst_row_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [31:0]                out_pixel_o,
  output logic                       in_border_o
);
  import lbs_pkg::*;

  cfg_t  cfg;
  logic  q_push, q_full, q_pop, q_empty;
  item_t q_in, q_out;

  // configuration and fit
  lbs_fit u_fit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // classification
  lbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push_i      (push),
    .full_o      (full),
    .func_i      (func_i),
    .src_col_i   (src_col_i),
    .src_row_i   (src_row_i),
    .src_pixel_i (src_pixel_i),
    .dst_col_i   (dst_col_i),
    .dst_row_i   (dst_row_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_in)
  );

  // decoupling queue
  lbs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  // mapping, store and blend
  lbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_pixel_o (out_pixel_o),
    .in_border_o (in_border_o)
  );

endmodule

@@ bench/lbs_checker.sv @@
// checker for the letterbox bilinear scaler: predicts every sample result and compares
// watches the apb port and both item channels; depends on lbs_pkg
`timescale 1ns / 1ps

module lbs_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  input  logic                       push,
  input  logic                       full,
  input  logic                       func_i,
  input  logic [lbs_pkg::SRC_CW-1:0] src_col_i,
  input  logic [lbs_pkg::SRC_CW-1:0] src_row_i,
  input  logic [31:0]                src_pixel_i,
  input  logic [lbs_pkg::DST_CW-1:0] dst_col_i,
  input  logic [lbs_pkg::DST_CW-1:0] dst_row_i,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [31:0]                out_pixel_o,
  input  logic                       in_border_o,
  output int                         fail_count,
  output int                         pending
);
  import lbs_pkg::*;

  // shadow copy of the configuration and the frame store
  longint unsigned src_w, src_h, win_w, win_h;
  logic            swap_rb, flip_y;
  logic [PIX_W-1:0] pixels [SRC_MAX_SIDE*SRC_MAX_SIDE];
  res_t            expected_px [$];

  function automatic longint unsigned clamp_side(longint unsigned v, longint unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // destination offset to 16.16 source position at pixel centers
  function automatic longint unsigned to_source(longint unsigned pos, longint unsigned slen,
                                                longint unsigned flen);
    longint unsigned q;
    q = (pos * 2 + 1) * slen * 32768 / flen;
    return (q < 32768) ? 0 : q - 32768;
  endfunction

  function automatic logic [31:0] texel(int unsigned col, int unsigned row);
    return {8'h00, pixels[row * SRC_MAX_SIDE + col]};
  endfunction

  function automatic logic [31:0] lerp(logic [31:0] p, logic [31:0] q, int unsigned w,
                                       logic [31:0] mask);
    return (((p & mask) * (256 - w) + (q & mask) * w) >> 8) & mask;
  endfunction

  // expected result of one sample
  function automatic res_t scale_point(longint unsigned x, longint unsigned y);
    longint unsigned fit_w, fit_h, off_x, off_y, fx, fy;
    int unsigned     x0, x1, y0, y1, wx, wy;
    logic [31:0]     a, b, c, d, px;
    res_t            r;
    fit_w = win_w;
    fit_h = win_w * src_h / src_w;
    if (fit_h > win_h) begin
      fit_h = win_h;
      fit_w = win_h * src_w / src_h;
    end
    off_x = (win_w - fit_w) / 2;
    off_y = (win_h - fit_h) / 2;
    if (x >= win_w || y >= win_h || x < off_x || x >= off_x + fit_w ||
        y < off_y || y >= off_y + fit_h) begin
      r.pixel  = BG_PIXEL;
      r.border = 1'b1;
      return r;
    end
    fx = to_source(x - off_x, src_w, fit_w);
    fy = to_source(y - off_y, src_h, fit_h);
    x0 = 32'(fx >> 16);
    y0 = 32'(fy >> 16);
    x1 = (x0 + 1 < src_w) ? x0 + 1 : x0;
    y1 = (y0 + 1 < src_h) ? y0 + 1 : y0;
    wx = 32'((fx & 64'hffff) >> 8);
    wy = 32'((fy & 64'hffff) >> 8);
    if (flip_y) begin
      y0 = 32'(src_h - 1 - y0);
      y1 = 32'(src_h - 1 - y1);
    end
    a = texel(x0, y0);
    b = texel(x1, y0);
    c = texel(x0, y1);
    d = texel(x1, y1);
    px = 32'hff000000
       | lerp(lerp(a, b, wx, 32'hff00ff), lerp(c, d, wx, 32'hff00ff), wy, 32'hff00ff)
       | lerp(lerp(a, b, wx, 32'hff00), lerp(c, d, wx, 32'hff00), wy, 32'hff00);
    if (swap_rb) px = {px[31:24], px[7:0], px[15:8], px[23:16]};
    r.pixel  = px;
    r.border = 1'b0;
    return r;
  endfunction

  assign pending = expected_px.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w      = SRC_RESET;
      src_h      = SRC_RESET;
      win_w      = DST_RESET;
      win_h      = DST_RESET;
      swap_rb    = 1'b0;
      flip_y     = 1'b0;
      fail_count = 0;
      expected_px.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_SRC_WIDTH:  src_w   = clamp_side(pwdata[8:0], SRC_MAX_SIDE);
          REG_SRC_HEIGHT: src_h   = clamp_side(pwdata[8:0], SRC_MAX_SIDE);
          REG_DST_WIDTH:  win_w   = clamp_side(pwdata[12:0], DST_MAX_SIDE);
          REG_DST_HEIGHT: win_h   = clamp_side(pwdata[12:0], DST_MAX_SIDE);
          REG_SWAP_RB:    swap_rb = pwdata[0];
          REG_FLIP_ROWS:  flip_y  = pwdata[0];
          default: ;
        endcase
      end
      // result side
      if (pop && !empty) begin
        if (expected_px.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result pixel %h border %b", $realtime,
                     out_pixel_o, in_border_o);
        end else begin
          if (out_pixel_o !== expected_px[0].pixel || in_border_o !== expected_px[0].border) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected pixel %h border %b, got pixel %h border %b",
                       $realtime, expected_px[0].pixel, expected_px[0].border,
                       out_pixel_o, in_border_o);
          end
          void'(expected_px.pop_front());
        end
      end
      // item side
      if (push && !full) begin
        if (func_i == FUNC_LOAD)
          pixels[src_row_i * SRC_MAX_SIDE + src_col_i] = src_pixel_i[PIX_W-1:0];
        else
          expected_px.push_back(scale_point(dst_col_i, dst_row_i));
      end
    end
  end

endmodule

@@ bench/testbench.sv @@
// top of the scaler testbench: clock, reset, stimulus, idling and verdict
// depends on lbs_pkg, letterbox_bilinear_scaler and lbs_checker
`timescale 1ns / 1ps

module testbench;
  import lbs_pkg::*;

  localparam logic     FUNC_SAMPLE = ~FUNC_LOAD;
  localparam logic [2:0] REG_NONE  = 3'd6;
  localparam int       DRAIN_WAIT = 80;
  localparam int       FILL_SIDE  = 16;
  localparam int       PHASE_ITEMS = 52;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              push = 1'b0, full;
  logic              func_i = FUNC_LOAD;
  logic [SRC_CW-1:0] src_col_i = '0, src_row_i = '0;
  logic [31:0]       src_pixel_i = '0;
  logic [DST_CW-1:0] dst_col_i = '0, dst_row_i = '0;
  logic              empty, pop = 1'b0;
  logic [31:0]       out_pixel_o;
  logic              in_border_o;
  int                fail_count, pending;

  // idle percentages of both sides and the long receiver hold-off request
  int unsigned send_idle = 0, recv_idle = 0;
  logic        hold_req = 1'b0;
  int unsigned cur_w = 256, cur_h = 256;

  // rows and columns that the directed full-size samples read
  logic [7:0]  probe_rc [8] = '{8'd0, 8'd1, 8'd126, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  letterbox_bilinear_scaler uut (.*);

  lbs_checker u_checker (.*);

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && hold_req) hold = 400;
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_item(logic fn, logic [7:0] col, logic [7:0] row, logic [31:0] pix,
                           logic [11:0] dc, logic [11:0] dr);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push        <= 1'b1;
    func_i      <= fn;
    src_col_i   <= col;
    src_row_i   <= row;
    src_pixel_i <= pix;
    dst_col_i   <= dc;
    dst_row_i   <= dr;
    do @(posedge clk_i); while (full);
  endtask

  task automatic sample_at(logic [11:0] dc, logic [11:0] dr);
    send_item(FUNC_SAMPLE, $urandom, $urandom, $urandom, dc, dr);
  endtask

  // wait for every result, then let the pipeline settle before a register write
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic configure(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh,
                           logic swap, logic flip);
    drain();
    reg_write(REG_SRC_WIDTH, sw);
    reg_write(REG_SRC_HEIGHT, sh);
    reg_write(REG_DST_WIDTH, dw);
    reg_write(REG_DST_HEIGHT, dh);
    reg_write(REG_SWAP_RB, swap);
    reg_write(REG_FLIP_ROWS, flip);
    cur_w = (dw == 0) ? 1 : (dw > DST_MAX_SIDE ? DST_MAX_SIDE : dw);
    cur_h = (dh == 0) ? 1 : (dh > DST_MAX_SIDE ? DST_MAX_SIDE : dh);
  endtask

  // two opposite corners and the center of the window plus a point just outside it
  task automatic probe_window();
    sample_at(0, 0);
    sample_at(cur_w - 1, cur_h - 1);
    sample_at(cur_w / 2, cur_h / 2);
    sample_at(cur_w, 0);
  endtask

  initial begin : stimulus
    int unsigned n_phase, mode;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill the corner of the store that the random sources cover
    for (int r = 0; r < FILL_SIDE; r++)
      for (int c = 0; c < FILL_SIDE; c++)
        send_item(FUNC_LOAD, 8'(c), 8'(r), $urandom, $urandom, $urandom);
    // entries that the directed full-size samples reach
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++)
        if (probe_rc[i] >= FILL_SIDE || probe_rc[j] >= FILL_SIDE)
          send_item(FUNC_LOAD, probe_rc[j], probe_rc[i], $urandom, $urandom, $urandom);

    // directed: reset setting, extreme fields, out-of-window points
    probe_window();
    sample_at(12'hfff, 12'hfff);
    sample_at(12'hfff, 0);
    // zero and oversized register values, unknown register
    configure(0, 511, 0, 8191, 1, 1);
    reg_write(REG_NONE, 32'hffffffff);
    probe_window();
    // degenerate fit: tall narrow window over a wide source
    configure(256, 1, 1, 4096, 0, 1);
    probe_window();
    // largest source into largest window, swapped
    configure(256, 256, 4096, 4096, 1, 0);
    probe_window();
    sample_at(4095, 4095);

    // random phases over the filled corner, cycling through the idle modes
    for (n_phase = 0; n_phase < 8; n_phase++) begin
      mode = n_phase % 4;
      if ($urandom_range(3) == 0)
        configure($urandom_range(1, FILL_SIDE), $urandom_range(1, FILL_SIDE),
                  $urandom_range(1, 4096), $urandom_range(1, 4096),
                  $urandom_range(1), $urandom_range(1));
      else
        configure($urandom_range(1, FILL_SIDE), $urandom_range(1, FILL_SIDE),
                  $urandom_range(1, 64), $urandom_range(1, 64),
                  $urandom_range(1), $urandom_range(1));
      send_idle = (mode == 1) ? 87 : (mode == 3) ? 31 : 0;
      recv_idle = (mode == 2) ? 87 : (mode == 3) ? 31 : 0;
      hold_req  = (n_phase == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // only samples during the hold-off so the block fills up
        if (n_phase != 4 && $urandom_range(4) == 0)
          send_item(FUNC_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if ($urandom_range(5) == 0)
          sample_at($urandom, $urandom);
        else
          sample_at($urandom_range(cur_w - 1), $urandom_range(cur_h - 1));
        hold_req = 1'b0;
      end
    end

    send_idle = 0;
    recv_idle = 0;
    drain();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
design/lbs_pkg.sv
design/lbs_fit.sv
design/lbs_front.sv
design/lbs_fifo.sv
design/lbs_back.sv
design/letterbox_bilinear_scaler.sv
bench/lbs_checker.sv
bench/testbench.sv
